[rtl/motion_event_window_capture_assert.svh]
// Assertion helpers shared by the capture block.
`ifndef MOTION_EVENT_WINDOW_CAPTURE_ASSERT_SVH
`define MOTION_EVENT_WINDOW_CAPTURE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MEWC_ASSERT_ALWAYS(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MEWC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/mewc_pkg.sv]
package mewc_pkg;

	localparam int RING_FRAMES_DEF = 64;
	localparam int PRE_FRAMES_DEF  = 16;
	localparam int POST_FRAMES_DEF = 48;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_NORM_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_JERK_LIMIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_JERK_FLOOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_NORM_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_FRAMES  = 3'd4;

	localparam logic [15:0] ACCEL_NORM_LIMIT_RST = 16'd3200;
	localparam logic [15:0] JERK_LIMIT_RST       = 16'd1280;
	localparam logic [15:0] GYRO_JERK_FLOOR_RST  = 16'd640;
	localparam logic [15:0] GYRO_NORM_LIMIT_RST  = 16'd4584;
	localparam logic [15:0] COOLDOWN_FRAMES_RST  = 16'd64;

	// trigger reason bits
	localparam logic [2:0] FLAG_ACCEL_HIGH = 3'b001;
	localparam logic [2:0] FLAG_JERK_HIGH  = 3'b010;
	localparam logic [2:0] FLAG_GYRO_JERK  = 3'b100;

	// 32-bit radicand, one result bit per step
	localparam int ROOT_STEPS  = 16;
	localparam int ROOT_STEP_W = $clog2(ROOT_STEPS);

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [47:0]        time_us;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] frame_accel_x;
		logic signed [15:0] frame_accel_y;
		logic signed [15:0] frame_accel_z;
		logic signed [15:0] frame_gyro_x;
		logic signed [15:0] frame_gyro_y;
		logic signed [15:0] frame_gyro_z;
		logic [47:0]        frame_time_us;
		logic [5:0]         frame_number;
		logic [31:0]        window_seq;
		logic [2:0]         trigger_reason;
		logic [31:0]        trigger_sample;
		logic               last_frame;
	} frame_t;

endpackage

[rtl/mewc_ifs.sv]
interface mewc_sample_if import mewc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mewc_frame_if import mewc_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mewc_cfg_if import mewc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mewc_ring_ram.sv]
module mewc_ring_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 144
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/mewc_isqrt.sv]
module mewc_isqrt import mewc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0]            rem_q;
	logic [31:0]            res_q;
	logic [ROOT_STEP_W-1:0] step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [31:0]            bit_w;
	logic [31:0]            trial;

	// step k tests bit 2k, from the top pair down
	assign bit_w = 32'd1 << {step_q, 1'b0};
	assign trial = res_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ROOT_STEP_W'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_w;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[15:0];

endmodule

[rtl/motion_event_window_capture.sv]
// Pre-trigger capture of six-axis samples. One sample item is taken at a time: acceptance,
// squaring on one shared 16x16 multiplier (three accel axes, three gyro axes, the gyro
// limit), the bit-pair square root unit (start, 16 steps, done) and trigger evaluation.
// When a window is due, the ring memory is read one frame per cycle into the output
// register while the frame channel applies no backpressure; the input stays closed
// until the last frame has moved into the output register, from which the last frame
// then leaves on the frame channel.
// The ring holds accel, gyro and timestamp of each sample in one memory word.
`include "motion_event_window_capture_assert.svh"

module motion_event_window_capture import mewc_pkg::*; #(
	parameter int RING_FRAMES = RING_FRAMES_DEF,
	parameter int PRE_FRAMES  = PRE_FRAMES_DEF,
	parameter int POST_FRAMES = POST_FRAMES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mewc_sample_if.sink  samples,
	mewc_frame_if.source frames,
	mewc_cfg_if.sink     cfg
);

	localparam int AW      = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
	localparam int CW      = $clog2(RING_FRAMES + 1);
	localparam int PRE_MOD = PRE_FRAMES % RING_FRAMES;
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_FRAMES - 1);
	localparam logic [CW-1:0] RING_CNT  = CW'(RING_FRAMES);
	localparam logic [AW:0]   PRE_OFS   = (AW + 1)'(PRE_MOD);
	localparam logic [AW:0]   RING_OFS  = (AW + 1)'(RING_FRAMES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_EVAL,
		ST_PUB
	} state_t;

	function automatic logic [15:0] mag16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	state_t      state_q;
	logic [15:0] accel_limit_q, jerk_limit_q, gyro_floor_q, gyro_limit_q, cooldown_q;

	sample_t     smp_q;
	logic [2:0]  sq_idx_q;
	logic [31:0] acc_a_q, acc_g_q, glim_q;
	logic        root_start_q;

	logic [AW-1:0] write_slot_q, cur_slot_q, ev_slot_q, rd_addr_q;
	logic [CW-1:0] fill_q, issue_cnt_q, pend_k_q;
	logic [31:0]   total_q, ev_sample_q, pub_sample_q, seq_q;
	logic          armed_q, prev_valid_q;
	logic [15:0]   prev_norm_q;
	logic [2:0]    ev_flags_q;
	logic          pend_q;
	logic          out_valid_q;
	frame_t        out_q;

	logic          in_acc;
	logic [15:0]   sq_op;
	logic [31:0]   sq_prod;
	logic          root_done;
	logic [15:0]   norm;
	logic [15:0]   jerk;
	logic          cool, open, arm_now, armed_n, post_ok, publish;
	logic [2:0]    flags;
	logic [AW-1:0] ev_slot_n, start_slot;
	logic [AW:0]   slot_ext;
	logic          issue_left, move, rd_en;
	sample_t       rdata;

	assign in_acc        = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;

	// configuration registers; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q <= ACCEL_NORM_LIMIT_RST;
			jerk_limit_q  <= JERK_LIMIT_RST;
			gyro_floor_q  <= GYRO_JERK_FLOOR_RST;
			gyro_limit_q  <= GYRO_NORM_LIMIT_RST;
			cooldown_q    <= COOLDOWN_FRAMES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ACCEL_NORM_LIMIT: accel_limit_q <= cfg.data;
				CFG_JERK_LIMIT:       jerk_limit_q  <= cfg.data;
				CFG_GYRO_JERK_FLOOR:  gyro_floor_q  <= cfg.data;
				CFG_GYRO_NORM_LIMIT:  gyro_limit_q  <= cfg.data;
				CFG_COOLDOWN_FRAMES:  cooldown_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// shared squarer
	always_comb begin
		unique case (sq_idx_q)
			3'd0:    sq_op = mag16(smp_q.accel_x);
			3'd1:    sq_op = mag16(smp_q.accel_y);
			3'd2:    sq_op = mag16(smp_q.accel_z);
			3'd3:    sq_op = mag16(smp_q.gyro_x);
			3'd4:    sq_op = mag16(smp_q.gyro_y);
			3'd5:    sq_op = mag16(smp_q.gyro_z);
			3'd6:    sq_op = gyro_limit_q;
			default: sq_op = '0;
		endcase
	end
	assign sq_prod = sq_op * sq_op;

	mewc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start_q),
		.radicand (acc_a_q),
		.done     (root_done),
		.root     (norm)
	);

	// trigger evaluation
	always_comb begin
		if (!prev_valid_q) begin
			jerk = '0;
		end else if (norm > prev_norm_q) begin
			jerk = norm - prev_norm_q;
		end else begin
			jerk = prev_norm_q - norm;
		end
		cool = (seq_q == '0) || ((total_q - pub_sample_q) >= 32'(cooldown_q));
		open = !armed_q && (32'(fill_q) > 32'(PRE_FRAMES)) && cool;
		flags = '0;
		if (norm > accel_limit_q) begin
			flags = flags | FLAG_ACCEL_HIGH;
		end
		if (jerk > jerk_limit_q) begin
			flags = flags | FLAG_JERK_HIGH;
		end
		if ((acc_g_q > glim_q) && (jerk > gyro_floor_q)) begin
			flags = flags | FLAG_GYRO_JERK;
		end
		arm_now = open && (flags != '0);
		armed_n = armed_q || arm_now;
		// arming now leaves exactly one collected frame
		post_ok = arm_now ? (POST_FRAMES <= 1)
		                  : ((total_q - ev_sample_q + 32'd1) >= 32'(POST_FRAMES));
		publish = armed_n && (total_q >= 32'(RING_FRAMES)) && (fill_q == RING_CNT) && post_ok;
		ev_slot_n = arm_now ? cur_slot_q : ev_slot_q;
		slot_ext = {1'b0, ev_slot_n};
		if (slot_ext >= PRE_OFS) begin
			slot_ext = slot_ext - PRE_OFS;
		end else begin
			slot_ext = slot_ext + RING_OFS - PRE_OFS;
		end
		start_slot = slot_ext[AW-1:0];
	end

	// window stream: rdata holds a frame while pend_q is set
	assign issue_left = (issue_cnt_q != RING_CNT);
	assign move       = pend_q && (!out_valid_q || frames.ready);
	assign rd_en      = (state_q == ST_PUB) && issue_left && (!pend_q || move);

	mewc_ring_ram #(
		.DEPTH (RING_FRAMES),
		.AW    (AW),
		.W     ($bits(sample_t))
	) u_ring (
		.clk   (clk),
		.we    (in_acc),
		.waddr (write_slot_q),
		.wdata (samples.data),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			smp_q        <= '0;
			sq_idx_q     <= '0;
			acc_a_q      <= '0;
			acc_g_q      <= '0;
			glim_q       <= '0;
			root_start_q <= 1'b0;
			write_slot_q <= '0;
			cur_slot_q   <= '0;
			fill_q       <= '0;
			total_q      <= '0;
			armed_q      <= 1'b0;
			ev_sample_q  <= '0;
			ev_slot_q    <= '0;
			ev_flags_q   <= '0;
			pub_sample_q <= '0;
			prev_valid_q <= 1'b0;
			prev_norm_q  <= '0;
			seq_q        <= '0;
			rd_addr_q    <= '0;
			issue_cnt_q  <= '0;
			pend_q       <= 1'b0;
			pend_k_q     <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			root_start_q <= (state_q == ST_SQ) && (sq_idx_q == 3'd6);

			if (move) begin
				out_valid_q                <= 1'b1;
				out_q.frame_accel_x        <= rdata.accel_x;
				out_q.frame_accel_y        <= rdata.accel_y;
				out_q.frame_accel_z        <= rdata.accel_z;
				out_q.frame_gyro_x         <= rdata.gyro_x;
				out_q.frame_gyro_y         <= rdata.gyro_y;
				out_q.frame_gyro_z         <= rdata.gyro_z;
				out_q.frame_time_us        <= rdata.time_us;
				out_q.frame_number         <= 6'(pend_k_q);
				out_q.window_seq           <= seq_q;
				out_q.trigger_reason       <= ev_flags_q;
				out_q.trigger_sample       <= ev_sample_q;
				out_q.last_frame           <= (pend_k_q == CW'(RING_FRAMES - 1));
			end else if (frames.ready) begin
				out_valid_q <= 1'b0;
			end

			if (rd_en) begin
				rd_addr_q   <= (rd_addr_q == LAST_SLOT) ? '0 : rd_addr_q + 1'b1;
				issue_cnt_q <= issue_cnt_q + 1'b1;
				pend_q      <= 1'b1;
				pend_k_q    <= issue_cnt_q;
			end else if (move) begin
				pend_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						smp_q        <= samples.data;
						cur_slot_q   <= write_slot_q;
						write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
						if (fill_q != RING_CNT) begin
							fill_q <= fill_q + 1'b1;
						end
						total_q  <= total_q + 32'd1;
						sq_idx_q <= '0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					sq_idx_q <= sq_idx_q + 3'd1;
					if (sq_idx_q == 3'd0) begin
						acc_a_q <= sq_prod;
					end else if (sq_idx_q < 3'd3) begin
						acc_a_q <= acc_a_q + sq_prod;
					end else if (sq_idx_q == 3'd3) begin
						acc_g_q <= sq_prod;
					end else if (sq_idx_q < 3'd6) begin
						acc_g_q <= acc_g_q + sq_prod;
					end else begin
						glim_q  <= sq_prod;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					prev_valid_q <= 1'b1;
					prev_norm_q  <= norm;
					if (arm_now) begin
						ev_sample_q <= total_q;
						ev_slot_q   <= cur_slot_q;
						ev_flags_q  <= flags;
					end
					if (publish) begin
						seq_q        <= seq_q + 32'd1;
						pub_sample_q <= arm_now ? total_q : ev_sample_q;
						armed_q      <= 1'b0;
						rd_addr_q    <= start_slot;
						issue_cnt_q  <= '0;
						state_q      <= ST_PUB;
					end else begin
						if (arm_now) begin
							armed_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_PUB: begin
					if (!issue_left && (!pend_q || move)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign frames.valid = out_valid_q;
	assign frames.data  = out_q;

	`MEWC_ASSERT_ALWAYS(a_fill_bound, fill_q <= RING_CNT, "fill level above ring depth")
	`MEWC_ASSERT_ALWAYS(a_root_in_state, root_done |-> (state_q == ST_ROOT),
		"root done out of place")
	`MEWC_ASSERT_ALWAYS(a_last_tag, (frames.valid && frames.data.last_frame) |->
		(frames.data.frame_number == 6'(RING_FRAMES - 1)), "last frame tag on wrong frame")
	`MEWC_ASSERT_NEXT(a_pub_blocks_input, (state_q == ST_EVAL) && publish, !samples.ready,
		"sample taken during window stream")

endmodule
